// ===== design/byte_stuffed_frame_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder assertion macros
// Concurrent assertion wrappers on clk and arst_n; define ASSERT_OFF to compile
// them out.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH
`define BYTE_STUFFED_FRAME_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
`define BSFE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);
`define BSFE_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);
`else
`define BSFE_ASSERT(lbl, prop, msg)
`define BSFE_NEVER(lbl, expr, msg)
`endif

`endif

// ===== design/bsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder package
// Shared constants, queue word type, sequencer phases and the CRC-32 step.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfe_pkg;

	localparam int SENDER_SLOTS = 4;
	localparam int SLOT_IW      = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QUEUE_PW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int CRC_BYTES    = 4;

	localparam logic [7:0]  START_CODE  = 8'hA5;
	localparam logic [7:0]  ESCAPE_CODE = 8'h5A;
	localparam logic [7:0]  PAD_BYTE    = 8'h00;
	localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
	localparam logic [31:0] CRC_SEED    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic       first;
		logic       last;
		logic [7:0] data;
		logic [7:0] len;
		logic [7:0] sender;
		logic [7:0] seq;
	} bsfe_item_t;

	typedef enum logic [2:0] {
		PH_BEGIN,
		PH_START,
		PH_LEN,
		PH_SENDER,
		PH_SEQ,
		PH_DATA,
		PH_CRC,
		PH_PAD
	} bsfe_phase_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {b, 24'h0};
		for (int k = 0; k < 8; k++) begin
			if (c[31]) begin
				c = {c[30:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[30:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		return (b == START_CODE) || (b == ESCAPE_CODE);
	endfunction

endpackage

`default_nettype wire

// ===== design/bsfe_front.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder front end
// Accepts input words, drops strays, attaches header fields and sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [7:0]          payload_byte,
	input  wire logic                first_byte,
	input  wire logic                last_byte,
	input  wire logic [7:0]          payload_length,
	input  wire logic [7:0]          sender_address,
	input  wire logic [1:0]          sender_slot,
	output logic                     push_valid,
	output bsfe_pkg::bsfe_item_t     push_item,
	input  wire logic                q_full
);
	import bsfe_pkg::*;

	logic [7:0]         seq_q [SENDER_SLOTS];
	logic               open_q;
	logic               accept;
	logic [SLOT_IW-1:0] idx;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign idx        = SLOT_IW'(32'(sender_slot) % SENDER_SLOTS);
	assign push_valid = accept && (first_byte || open_q);

	always_comb begin
		push_item.first  = first_byte;
		push_item.last   = last_byte;
		push_item.data   = payload_byte;
		push_item.len    = payload_length;
		push_item.sender = sender_address;
		push_item.seq    = seq_q[idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			for (int i = 0; i < SENDER_SLOTS; i++) begin
				seq_q[i] <= 8'h00;
			end
		end else if (accept) begin
			open_q <= (first_byte || open_q) && !last_byte;
			if (first_byte) begin
				seq_q[idx] <= seq_q[idx] + 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bsfe_queue.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder word queue
// Short FIFO between front end and byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfe_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	input  bsfe_pkg::bsfe_item_t     push_item,
	output logic                     q_full,
	output logic                     head_valid,
	output bsfe_pkg::bsfe_item_t     head_item,
	input  wire logic                pop
);
	import bsfe_pkg::*;

	bsfe_item_t          mem [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_q;
	logic [QUEUE_PW-1:0] rd_q;
	logic [QUEUE_CW-1:0] count_q;

	assign q_full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push_valid) begin
				wr_q <= (wr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QUEUE_PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QUEUE_PW'(1);
			end
			if (push_valid && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push_valid) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/bsfe_back.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder back end
// Byte sequencer: header, stuffing, CRC-32, padding, output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_stuffed_frame_encoder_macros.svh"

module bsfe_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  bsfe_pkg::bsfe_item_t     head_item,
	output logic                     pop,
	output logic                     byte_valid,
	input  wire logic                byte_stall,
	output logic [7:0]               frame_byte,
	output logic                     end_of_frame,
	output logic                     last_of_item
);
	import bsfe_pkg::*;

	bsfe_phase_t phase_q, phase_d, eff;
	logic        esc_q;
	logic [1:0]  idx_q, idx_d;
	logic [1:0]  pos_q, pos_next;
	logic [31:0] crc_q, crc_d, crc_out;
	logic        vld_q, eof_q, lof_q;
	logic [7:0]  byte_q;
	logic        out_ready, emit, stuffable, need_esc, fin, eof;
	logic [7:0]  cur_byte, crc_byte, emit_byte;

	assign out_ready = !vld_q || !byte_stall;
	assign emit      = head_valid && out_ready;
	assign eff       = (phase_q == PH_BEGIN) ? (head_item.first ? PH_START : PH_DATA) : phase_q;
	assign crc_out   = ~crc_q;
	assign crc_byte  = crc_out[{~idx_q, 3'b000} +: 8];

	// byte selection and escape decision
	always_comb begin
		stuffable = 1'b0;
		case (eff)
			PH_START:  cur_byte = START_CODE;
			PH_LEN:    begin cur_byte = head_item.len;  stuffable = 1'b1; end
			PH_SENDER: cur_byte = head_item.sender;
			PH_SEQ:    begin cur_byte = head_item.seq;  stuffable = 1'b1; end
			PH_DATA:   begin cur_byte = head_item.data; stuffable = 1'b1; end
			PH_CRC:    begin cur_byte = crc_byte;       stuffable = 1'b1; end
			PH_PAD:    cur_byte = PAD_BYTE;
			default:   cur_byte = PAD_BYTE;
		endcase
		need_esc  = stuffable && is_special(cur_byte) && !esc_q;
		emit_byte = need_esc ? ESCAPE_CODE : cur_byte;
		pos_next  = (eff == PH_START) ? 2'd1 : pos_q + 2'd1;
		eof       = fin && (eff != PH_DATA);
		pop       = fin;
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		fin     = 1'b0;
		if (emit && !need_esc) begin
			case (eff)
				PH_START:  phase_d = PH_LEN;
				PH_LEN:    phase_d = PH_SENDER;
				PH_SENDER: phase_d = PH_SEQ;
				PH_SEQ:    phase_d = PH_DATA;
				PH_DATA: begin
					if (head_item.last) begin
						phase_d = PH_CRC;
					end else begin
						fin     = 1'b1;
						phase_d = PH_BEGIN;
					end
				end
				PH_CRC: begin
					if (idx_q == 2'(CRC_BYTES - 1)) begin
						idx_d = '0;
						if (pos_next == '0) begin
							fin     = 1'b1;
							phase_d = PH_BEGIN;
						end else begin
							phase_d = PH_PAD;
						end
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
				PH_PAD: begin
					if (pos_next == '0) begin
						fin     = 1'b1;
						phase_d = PH_BEGIN;
					end
				end
				default: phase_d = PH_BEGIN;
			endcase
		end
	end

	always_comb begin
		crc_d = crc_q;
		if (emit && !need_esc) begin
			case (eff)
				PH_START:                            crc_d = crc_feed(CRC_SEED, START_CODE);
				PH_LEN, PH_SENDER, PH_SEQ, PH_DATA: crc_d = crc_feed(crc_q, cur_byte);
				default:                             crc_d = crc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BEGIN;
			esc_q   <= 1'b0;
			idx_q   <= '0;
			pos_q   <= '0;
			crc_q   <= CRC_SEED;
			vld_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			crc_q   <= crc_d;
			if (emit) begin
				esc_q <= need_esc;
				pos_q <= pos_next;
				vld_q <= 1'b1;
			end else if (!byte_stall) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= emit_byte;
			eof_q  <= eof;
			lof_q  <= fin;
		end
	end

	assign byte_valid   = vld_q;
	assign frame_byte   = byte_q;
	assign end_of_frame = eof_q;
	assign last_of_item = lof_q;

	`BSFE_ASSERT(a_esc_special, esc_q |-> head_valid && is_special(cur_byte), "lone escape")
	`BSFE_ASSERT(a_eof_last, vld_q && eof_q |-> lof_q, "end of frame not last of word")
	`BSFE_ASSERT(a_eof_aligned, vld_q && eof_q |-> pos_q == 2'd0, "frame not padded")
	`BSFE_NEVER(a_crc_idx_phase, (idx_q != 2'd0) && (phase_q != PH_CRC), "stray CRC index")

endmodule

`default_nettype wire

// ===== design/byte_stuffed_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Byte-stuffed frame encoder
// Frames payload bytes with header, escape stuffing, CRC-32 and padding.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  item     item_valid/item_stall   payload_byte first_byte last_byte
//                                   payload_length sender_address sender_slot
//  byte     byte_valid/byte_stall   frame_byte end_of_frame last_of_item
//
//  One output byte per cycle when not stalled and a word is queued; a plain
//  payload word gives 1 byte, 2 when escaped; a first word adds 4-6, a last
//  word 4-11 (CRC, pad). A two-word queue decouples input accept from the
//  sequencer; item_stall is high only while it is full. Output is a register
//  held on byte_stall. Reset clears sequence counters, frame state and the CRC.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stuffed_frame_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_stall,
	input  wire logic [7:0] payload_byte,
	input  wire logic       first_byte,
	input  wire logic       last_byte,
	input  wire logic [7:0] payload_length,
	input  wire logic [7:0] sender_address,
	input  wire logic [1:0] sender_slot,
	output logic            byte_valid,
	input  wire logic       byte_stall,
	output logic [7:0]      frame_byte,
	output logic            end_of_frame,
	output logic            last_of_item
);
	import bsfe_pkg::*;

	logic       push_valid, q_full, head_valid, pop;
	bsfe_item_t push_item, head_item;

	bsfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.payload_byte   (payload_byte),
		.first_byte     (first_byte),
		.last_byte      (last_byte),
		.payload_length (payload_length),
		.sender_address (sender_address),
		.sender_slot    (sender_slot),
		.push_valid     (push_valid),
		.push_item      (push_item),
		.q_full         (q_full)
	);

	bsfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.q_full     (q_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop)
	);

	bsfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.frame_byte   (frame_byte),
		.end_of_frame (end_of_frame),
		.last_of_item (last_of_item)
	);

endmodule

`default_nettype wire
